/* rtl/ftpp_pkg.sv */
package ftpp_pkg;

  localparam int MAX_LEVELS = 8;

  // item pipeline after the front stages: divider, root and cosine steps
  localparam int NSTG = 47;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_ROT0   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROT1   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROT2   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TRANS  = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FOCAL  = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PRINC  = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_BOUNDS = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 4'd7;

  localparam logic [62:0] ROT0_RST  = 63'd524288;
  localparam logic [62:0] ROT1_RST  = 63'd1099511627776;
  localparam logic [62:0] ROT2_RST  = 63'd2305843009213693952;
  localparam logic [19:0] SCALE_RST = 20'd543949;

  localparam logic [40:0] SF_ONE = 41'd16384;
  localparam logic [40:0] Q_CAP  = 41'h100_0000_0000;

  typedef struct packed {
    logic                          vld;
    logic                          ok;
    logic                          negx;
    logic                          negy;
    logic [41:0]                   dep;
    logic [42:0]                   remx;
    logic [42:0]                   remy;
    logic [40:0]                   lowx;
    logic [40:0]                   lowy;
    logic [40:0]                   qx;
    logic [40:0]                   qy;
    logic                          satx;
    logic                          saty;
    logic [47:0]                   sqv;
    logic [25:0]                   srem;
    logic [23:0]                   root;
    logic                          negd;
    logic [44:0]                   adot;
    logic [24:0]                   crem;
    logic [19:0]                   lowc;
    logic [19:0]                   cq;
    logic                          csat;
    logic                          dz;
    logic [19:0]                   near;
    logic [19:0]                   far;
    logic signed [20:0]            cosl;
    logic [MAX_LEVELS-1:0][60:0]   nsf;
    logic [3:0]                    lvl;
    logic signed [42:0]            u;
    logic signed [42:0]            v;
    logic                          oin;
    logic [31:0]                   ou;
    logic [31:0]                   ov;
    logic [20:0]                   ovc;
  } stage_t;

endpackage

/* rtl/frustum_test_project_point.sv */
// one word per cycle sustained while the output is not stalled
// depth is set by the 24-step square root followed by the 20-step cosine divider; the
// 41-step projection dividers run beside them; one restoring step per stage
// a stall at the output freezes the whole pipe; in_tready follows the output stall
// reset clears all valid bits and loads the register defaults; the scale table
// is rebuilt level by level from the scale register after a write to it
module frustum_test_project_point import ftpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // world_x, world_y, world_z, normal_x, normal_y, normal_z, near_distance,
  // far_distance, cos_limit
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // proj_u, proj_v, scale_level, view_cos
  output logic [OUT_DATA_W-1:0] out_tdata,
  // in_view
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [62:0] rot_r [3];
  logic [62:0] trans_r;
  logic [63:0] focal_r;
  logic [63:0] princ_r;
  logic [31:0] bounds_r;
  logic [19:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT0_RST;
      rot_r[1] <= ROT1_RST;
      rot_r[2] <= ROT2_RST;
      trans_r  <= '0;
      focal_r  <= '0;
      princ_r  <= '0;
      bounds_r <= '0;
      scale_r  <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROT0:   rot_r[0] <= cfg_wdata[62:0];
        REG_ROT1:   rot_r[1] <= cfg_wdata[62:0];
        REG_ROT2:   rot_r[2] <= cfg_wdata[62:0];
        REG_TRANS:  trans_r  <= cfg_wdata[62:0];
        REG_FOCAL:  focal_r  <= cfg_wdata;
        REG_PRINC:  princ_r  <= cfg_wdata;
        REG_BOUNDS: bounds_r <= cfg_wdata[31:0];
        REG_SCALE:  scale_r  <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  logic signed [20:0] rot_m [3][3];
  logic signed [20:0] tr_v [3];
  logic signed [20:0] wp [3];
  logic signed [20:0] nv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_m[i][j] = rot_r[i][21*j +: 21];
      end
      tr_v[i] = trans_r[21*i +: 21];
      wp[i]   = in_tdata[21*i +: 21];
      nv[i]   = in_tdata[63+21*i +: 21];
    end
  end

  // scale factor table, free running from the register
  logic [40:0] sf_r   [MAX_LEVELS];
  logic [40:0] sf_nxt [MAX_LEVELS];

  always_comb begin
    logic [56:0] prod;
    prod = '0;
    sf_nxt[0] = SF_ONE;
    for (int j = 1; j < MAX_LEVELS; j++) begin
      prod = 57'(sf_r[j-1]) * 57'(scale_r[15:0]) + 57'd8192;
      if (prod[56:14] > 43'(Q_CAP)) begin
        sf_nxt[j] = Q_CAP;
      end else begin
        sf_nxt[j] = prod[54:14];
      end
    end
  end

  always_ff @(posedge clk) begin
    sf_r <= sf_nxt;
  end

  logic en;
  logic [4:0] lvl_cnt;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    lvl_cnt = {1'b0, scale_r[19:16]};
    if (lvl_cnt == 5'd0) begin
      lvl_cnt = 5'd1;
    end else if (lvl_cnt > 5'(MAX_LEVELS)) begin
      lvl_cnt = 5'(MAX_LEVELS);
    end
  end

  // front stage 1: products of rotation with point and with translation
  logic               v1_r;
  logic signed [41:0] rp1_r [3][3];
  logic signed [41:0] rt1_r [3][3];
  logic signed [41:0] rp1_nxt [3][3];
  logic signed [41:0] rt1_nxt [3][3];
  logic signed [20:0] p1_r [3];
  logic signed [20:0] n1_r [3];
  logic [19:0]        near1_r, far1_r;
  logic signed [20:0] cos1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rp1_nxt[i][j] = 42'(rot_m[i][j]) * 42'(wp[j]);
        rt1_nxt[i][j] = 42'(rot_m[j][i]) * 42'(tr_v[j]);
      end
    end
  end

  // front stage 2: camera frame point and offset from the camera centre
  logic               v2_r;
  logic signed [42:0] pc2_r [3];
  logic signed [42:0] po2_r [3];
  logic signed [42:0] pc2_nxt [3];
  logic signed [42:0] po2_nxt [3];
  logic signed [20:0] n2_r [3];
  logic [19:0]        near2_r, far2_r;
  logic signed [20:0] cos2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc2_nxt[i] = (43'(tr_v[i]) <<< 19) + 43'(rp1_r[i][0]) + 43'(rp1_r[i][1])
                   + 43'(rp1_r[i][2]);
      po2_nxt[i] = (43'(p1_r[i]) <<< 19) + 43'(rt1_r[i][0]) + 43'(rt1_r[i][1])
                   + 43'(rt1_r[i][2]);
    end
  end

  // front stage 3: rounding to Q.10, depth test, magnitudes
  logic               v3_r, ok3_r, negx3_r, negy3_r;
  logic signed [23:0] c3_r [3];
  logic signed [23:0] c3_nxt [3];
  logic [41:0]        ax3_r, ay3_r, dep3_r;
  logic signed [20:0] n3_r [3];
  logic [19:0]        near3_r, far3_r;
  logic signed [20:0] cos3_r;

  always_comb begin
    logic [42:0] mg;
    logic [42:0] rnd;
    mg  = '0;
    rnd = '0;
    for (int i = 0; i < 3; i++) begin
      mg  = po2_r[i][42] ? 43'(-po2_r[i]) : 43'(po2_r[i]);
      rnd = (mg + 43'd262144) >> 19;
      c3_nxt[i] = po2_r[i][42] ? -$signed(rnd[23:0]) : $signed(rnd[23:0]);
    end
  end

  // front stage 4: split focal products, squares and dot terms
  logic               v4_r, ok4_r, negx4_r, negy4_r;
  logic [52:0]        pxl4_r, pxh4_r, pyl4_r, pyh4_r;
  logic [46:0]        cc4_r [3];
  logic signed [44:0] cn4_r [3];
  logic [46:0]        cc4_nxt [3];
  logic signed [44:0] cn4_nxt [3];
  logic [41:0]        dep4_r;
  logic [19:0]        near4_r, far4_r;
  logic signed [20:0] cos4_r;

  always_comb begin
    logic signed [47:0] sq_t;
    sq_t = '0;
    for (int i = 0; i < 3; i++) begin
      sq_t       = 48'(c3_r[i]) * 48'(c3_r[i]);
      cc4_nxt[i] = sq_t[46:0];
      cn4_nxt[i] = 45'(c3_r[i]) * 45'(n3_r[i]);
    end
  end

  // front stage 5: dividends, sum of squares, dot product
  logic               v5_r, ok5_r, negx5_r, negy5_r;
  logic [73:0]        nx5_r, ny5_r;
  logic [47:0]        sq5_r;
  logic signed [45:0] dot5_r;
  logic [41:0]        dep5_r;
  logic [19:0]        near5_r, far5_r;
  logic signed [20:0] cos5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp1_r   <= rp1_nxt;
      rt1_r   <= rt1_nxt;
      p1_r    <= wp;
      n1_r    <= nv;
      near1_r <= in_tdata[145:126];
      far1_r  <= in_tdata[165:146];
      cos1_r  <= in_tdata[186:166];

      pc2_r   <= pc2_nxt;
      po2_r   <= po2_nxt;
      n2_r    <= n1_r;
      near2_r <= near1_r;
      far2_r  <= far1_r;
      cos2_r  <= cos1_r;

      c3_r    <= c3_nxt;
      ok3_r   <= (pc2_r[2] > 43'sd0);
      negx3_r <= pc2_r[0][42];
      negy3_r <= pc2_r[1][42];
      ax3_r   <= pc2_r[0][42] ? 42'(-pc2_r[0]) : pc2_r[0][41:0];
      ay3_r   <= pc2_r[1][42] ? 42'(-pc2_r[1]) : pc2_r[1][41:0];
      dep3_r  <= pc2_r[2][41:0];
      n3_r    <= n2_r;
      near3_r <= near2_r;
      far3_r  <= far2_r;
      cos3_r  <= cos2_r;

      pxl4_r  <= 53'(focal_r[31:0]) * 53'(ax3_r[20:0]);
      pxh4_r  <= 53'(focal_r[31:0]) * 53'(ax3_r[41:21]);
      pyl4_r  <= 53'(focal_r[63:32]) * 53'(ay3_r[20:0]);
      pyh4_r  <= 53'(focal_r[63:32]) * 53'(ay3_r[41:21]);
      cc4_r   <= cc4_nxt;
      cn4_r   <= cn4_nxt;
      ok4_r   <= ok3_r;
      negx4_r <= negx3_r;
      negy4_r <= negy3_r;
      dep4_r  <= dep3_r;
      near4_r <= near3_r;
      far4_r  <= far3_r;
      cos4_r  <= cos3_r;

      nx5_r   <= 74'(pxl4_r) + (74'(pxh4_r) << 21);
      ny5_r   <= 74'(pyl4_r) + (74'(pyh4_r) << 21);
      sq5_r   <= 48'(cc4_r[0]) + 48'(cc4_r[1]) + 48'(cc4_r[2]);
      dot5_r  <= 46'(cn4_r[0]) + 46'(cn4_r[1]) + 46'(cn4_r[2]);
      ok5_r   <= ok4_r;
      negx5_r <= negx4_r;
      negy5_r <= negy4_r;
      dep5_r  <= dep4_r;
      near5_r <= near4_r;
      far5_r  <= far4_r;
      cos5_r  <= cos4_r;
    end
  end

  stage_t st_r   [NSTG];
  stage_t st_nxt [NSTG];

  // first step stage: saturation checks and divider, root setup
  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].vld  = v5_r;
    st_nxt[0].ok   = ok5_r;
    st_nxt[0].negx = negx5_r;
    st_nxt[0].negy = negy5_r;
    st_nxt[0].dep  = dep5_r;
    st_nxt[0].satx = ({9'b0, nx5_r[73:41]} >= dep5_r);
    st_nxt[0].saty = ({9'b0, ny5_r[73:41]} >= dep5_r);
    st_nxt[0].remx = {10'b0, nx5_r[73:41]};
    st_nxt[0].remy = {10'b0, ny5_r[73:41]};
    st_nxt[0].lowx = nx5_r[40:0];
    st_nxt[0].lowy = ny5_r[40:0];
    st_nxt[0].sqv  = sq5_r;
    st_nxt[0].negd = dot5_r[45];
    st_nxt[0].adot = dot5_r[45] ? 45'(-dot5_r) : dot5_r[44:0];
    st_nxt[0].near = near5_r;
    st_nxt[0].far  = far5_r;
    st_nxt[0].cosl = cos5_r;
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_step
    always_comb begin
      logic [42:0]        tx, ty;
      logic [27:0]        trm, ttr;
      logic [24:0]        tc;
      logic [40:0]        mqx, mqy;
      logic [31:0]        bx, by;
      logic signed [20:0] vc;
      logic               pass;
      tx   = '0;
      ty   = '0;
      trm  = '0;
      ttr  = '0;
      tc   = '0;
      mqx  = '0;
      mqy  = '0;
      bx   = '0;
      by   = '0;
      vc   = '0;
      pass = 1'b0;
      st_nxt[k] = st_r[k-1];

      // projection quotient, one bit per stage from bit 40 down
      if (k <= 41) begin
        tx = {st_r[k-1].remx[41:0], st_r[k-1].lowx[40]};
        ty = {st_r[k-1].remy[41:0], st_r[k-1].lowy[40]};
        if (tx >= {1'b0, st_r[k-1].dep}) begin
          st_nxt[k].remx = tx - {1'b0, st_r[k-1].dep};
          st_nxt[k].qx   = {st_r[k-1].qx[39:0], 1'b1};
        end else begin
          st_nxt[k].remx = tx;
          st_nxt[k].qx   = {st_r[k-1].qx[39:0], 1'b0};
        end
        if (ty >= {1'b0, st_r[k-1].dep}) begin
          st_nxt[k].remy = ty - {1'b0, st_r[k-1].dep};
          st_nxt[k].qy   = {st_r[k-1].qy[39:0], 1'b1};
        end else begin
          st_nxt[k].remy = ty;
          st_nxt[k].qy   = {st_r[k-1].qy[39:0], 1'b0};
        end
        st_nxt[k].lowx = {st_r[k-1].lowx[39:0], 1'b0};
        st_nxt[k].lowy = {st_r[k-1].lowy[39:0], 1'b0};
      end

      // square root, two radicand bits per stage
      if (k <= 24) begin
        trm = {st_r[k-1].srem, st_r[k-1].sqv[47:46]};
        ttr = {2'b0, st_r[k-1].root, 2'b01};
        if (trm >= ttr) begin
          st_nxt[k].srem = 26'(trm - ttr);
          st_nxt[k].root = {st_r[k-1].root[22:0], 1'b1};
        end else begin
          st_nxt[k].srem = trm[25:0];
          st_nxt[k].root = {st_r[k-1].root[22:0], 1'b0};
        end
        st_nxt[k].sqv = {st_r[k-1].sqv[45:0], 2'b0};
      end

      // distance known: range test, cosine divider setup, scale products
      if (k == 25) begin
        st_nxt[k].ok   = st_r[k-1].ok && (st_r[k-1].root >= {4'b0, st_r[k-1].near})
                         && (st_r[k-1].root <= {4'b0, st_r[k-1].far});
        st_nxt[k].dz   = (st_r[k-1].root == 24'd0);
        st_nxt[k].csat = (st_r[k-1].adot[44:20] >= {1'b0, st_r[k-1].root});
        st_nxt[k].crem = st_r[k-1].adot[44:20];
        st_nxt[k].lowc = st_r[k-1].adot[19:0];
        st_nxt[k].cq   = '0;
        for (int j = 0; j < MAX_LEVELS; j++) begin
          st_nxt[k].nsf[j] = 61'(st_r[k-1].near) * 61'(sf_r[j]);
        end
      end else begin
        st_nxt[k].nsf = '0;
      end

      // first qualifying level wins, top level otherwise
      if (k == 26) begin
        st_nxt[k].lvl = 4'(lvl_cnt - 5'd1);
        for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
          if (5'(j) < lvl_cnt && st_r[k-1].nsf[j] >= {23'b0, st_r[k-1].root, 14'b0}) begin
            st_nxt[k].lvl = 4'(j);
          end
        end
      end

      // cosine quotient, bits 19 down to 0
      if (k >= 26 && k <= 45) begin
        tc = {st_r[k-1].crem[23:0], st_r[k-1].lowc[19]};
        if (tc >= {1'b0, st_r[k-1].root}) begin
          st_nxt[k].crem = tc - {1'b0, st_r[k-1].root};
          st_nxt[k].cq   = {st_r[k-1].cq[18:0], 1'b1};
        end else begin
          st_nxt[k].crem = tc;
          st_nxt[k].cq   = {st_r[k-1].cq[18:0], 1'b0};
        end
        st_nxt[k].lowc = {st_r[k-1].lowc[18:0], 1'b0};
      end

      // pixel coordinates from the capped quotients
      if (k == 42) begin
        mqx = (st_r[k-1].satx || st_r[k-1].qx > Q_CAP) ? Q_CAP : st_r[k-1].qx;
        mqy = (st_r[k-1].saty || st_r[k-1].qy > Q_CAP) ? Q_CAP : st_r[k-1].qy;
        st_nxt[k].u = (st_r[k-1].negx ? -$signed({2'b0, mqx}) : $signed({2'b0, mqx}))
                      + $signed({11'b0, princ_r[31:0]});
        st_nxt[k].v = (st_r[k-1].negy ? -$signed({2'b0, mqy}) : $signed({2'b0, mqy}))
                      + $signed({11'b0, princ_r[63:32]});
      end

      if (k == 43) begin
        bx = {bounds_r[15:0], 16'b0};
        by = {bounds_r[31:16], 16'b0};
        st_nxt[k].ok = st_r[k-1].ok && !st_r[k-1].u[42] && !st_r[k-1].v[42]
                       && (st_r[k-1].u <= $signed({11'b0, bx}))
                       && (st_r[k-1].v <= $signed({11'b0, by}));
      end

      // output word, zeroed on reject
      if (k == NSTG - 1) begin
        if (st_r[k-1].dz) begin
          vc = '0;
        end else if (st_r[k-1].csat) begin
          vc = st_r[k-1].negd ? -21'sd1048576 : 21'sd1048575;
        end else begin
          vc = st_r[k-1].negd ? -$signed({1'b0, st_r[k-1].cq}) : $signed({1'b0, st_r[k-1].cq});
        end
        pass = st_r[k-1].ok && (vc >= st_r[k-1].cosl);
        st_nxt[k].oin = pass;
        st_nxt[k].ovc = pass ? vc : '0;
        st_nxt[k].lvl = pass ? st_r[k-1].lvl : '0;
        if (!pass) begin
          st_nxt[k].ou = '0;
        end else if (st_r[k-1].u > 43'sd2147483647) begin
          st_nxt[k].ou = 32'h7fff_ffff;
        end else begin
          st_nxt[k].ou = st_r[k-1].u[31:0];
        end
        if (!pass) begin
          st_nxt[k].ov = '0;
        end else if (st_r[k-1].v > 43'sd2147483647) begin
          st_nxt[k].ov = 32'h7fff_ffff;
        end else begin
          st_nxt[k].ov = st_r[k-1].v[31:0];
        end
      end
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_tvalid = st_r[NSTG-1].vld;
  assign out_tuser  = st_r[NSTG-1].oin;
  assign out_tdata  = {st_r[NSTG-1].ovc, st_r[NSTG-1].lvl[2:0], st_r[NSTG-1].ov,
                       st_r[NSTG-1].ou};

endmodule

/* rtl/ftpp_checker.sv */
module ftpp_checker import ftpp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // the input side only waits while a finished word is held back
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected point carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind frustum_test_project_point ftpp_checker u_ftpp_checker (.*);

/* test/frustum_test_project_point_check.sv */
module frustum_test_project_point_check import ftpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               in_view;
    logic [31:0]        u;
    logic [31:0]        v;
    logic [2:0]         lvl;
    logic signed [20:0] vcos;
  } view_t;

  localparam longint QCAP = 64'd1 << 40;

  logic [63:0] cam_reg [16];
  view_t       view_q [$];

  function automatic longint sx21(logic [20:0] x);
    return longint'($signed(x));
  endfunction

  function automatic longint proj(longint num, longint dep, logic [31:0] f, logic [31:0] cc);
    logic [127:0] prod;
    logic [127:0] q;
    longint       a;
    a = (num < 0) ? -num : num;
    prod = 128'(f) * 128'(a);
    q = prod / 128'(dep);
    if (q > 128'(QCAP)) q = 128'(QCAP);
    return ((num < 0) ? -longint'(q[63:0]) : longint'(q[63:0])) + longint'({32'b0, cc});
  endfunction

  function automatic longint round_q10(longint x);
    longint m;
    m = (((x < 0) ? -x : x) + (64'd1 << 18)) >>> 19;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic view_t project_point(logic [IN_DATA_W-1:0] d);
    view_t           res;
    longint          rot [3][3];
    longint          tr [3];
    longint          p [3];
    longint          nv [3];
    longint          pc [3];
    longint          po [3];
    longint          c, u, v, dot, vc, cosl;
    longint unsigned sq, dlen, m, sf, s, cnt, lvl, nearv, farv;
    bit              found;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) rot[i][j] = sx21(cam_reg[i][21*j +: 21]);
      tr[i] = sx21(cam_reg[REG_TRANS][21*i +: 21]);
      p[i]  = sx21(d[21*i +: 21]);
      nv[i] = sx21(d[63 + 21*i +: 21]);
    end
    nearv = d[145:126];
    farv  = d[165:146];
    cosl  = sx21(d[186:166]);
    for (int i = 0; i < 3; i++) begin
      pc[i] = tr[i] * 524288;
      po[i] = p[i] * 524288;
      for (int j = 0; j < 3; j++) begin
        pc[i] += rot[i][j] * p[j];
        po[i] += rot[j][i] * tr[j];
      end
    end
    if (pc[2] <= 0) return res;
    u = proj(pc[0], pc[2], cam_reg[REG_FOCAL][31:0], cam_reg[REG_PRINC][31:0]);
    v = proj(pc[1], pc[2], cam_reg[REG_FOCAL][63:32], cam_reg[REG_PRINC][63:32]);
    if (u < 0 || u > longint'({cam_reg[REG_BOUNDS][15:0], 16'b0})) return res;
    if (v < 0 || v > longint'({cam_reg[REG_BOUNDS][31:16], 16'b0})) return res;
    sq = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      c = round_q10(po[i]);
      sq += longint'(c * c);
      dot += c * nv[i];
    end
    dlen = int_sqrt(sq);
    if (dlen < nearv || dlen > farv) return res;
    if (dlen == 0) begin
      vc = 0;
    end else begin
      m = longint'((dot < 0) ? -dot : dot) / dlen;
      if (dot < 0) vc = (m > 1048576) ? -1048576 : -longint'(m);
      else vc = (m > 1048575) ? 1048575 : longint'(m);
    end
    if (vc < cosl) return res;
    s = cam_reg[REG_SCALE][15:0];
    cnt = cam_reg[REG_SCALE][19:16];
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_LEVELS) cnt = MAX_LEVELS;
    lvl = cnt - 1;
    sf = 16384;
    found = 0;
    for (longint unsigned k = 0; k < cnt && !found; k++) begin
      if (nearv * sf >= (dlen << 14)) begin
        lvl = k;
        found = 1;
      end else begin
        sf = (sf * s + 8192) >> 14;
        if (sf > QCAP) sf = QCAP;
      end
    end
    res.in_view = 1'b1;
    res.u = (u > 2147483647) ? 32'h7fffffff : u[31:0];
    res.v = (v > 2147483647) ? 32'h7fffffff : v[31:0];
    res.lvl = lvl[2:0];
    res.vcos = vc[20:0];
    return res;
  endfunction

  always @(posedge clk) begin
    view_t got, want;
    if (!rst_n) begin
      cam_reg[REG_ROT0]   <= 64'(ROT0_RST);
      cam_reg[REG_ROT1]   <= 64'(ROT1_RST);
      cam_reg[REG_ROT2]   <= 64'(ROT2_RST);
      cam_reg[REG_TRANS]  <= '0;
      cam_reg[REG_FOCAL]  <= '0;
      cam_reg[REG_PRINC]  <= '0;
      cam_reg[REG_BOUNDS] <= '0;
      cam_reg[REG_SCALE]  <= 64'(SCALE_RST);
      view_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROT0, REG_ROT1, REG_ROT2, REG_TRANS: cam_reg[cfg_addr] <= {1'b0, cfg_wdata[62:0]};
          REG_FOCAL, REG_PRINC:                    cam_reg[cfg_addr] <= cfg_wdata;
          REG_BOUNDS: cam_reg[cfg_addr] <= {32'b0, cfg_wdata[31:0]};
          REG_SCALE:  cam_reg[cfg_addr] <= {44'b0, cfg_wdata[19:0]};
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) view_q = {view_q, project_point(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[66:64], out_tdata[87:67]};
        if (view_q.size() == 0) begin
          $display("%0t: unexpected word, got %h", $time, got);
          fails++;
        end else begin
          want = view_q.pop_front();
          if (got.in_view !== want.in_view || got.u !== want.u || got.v !== want.v ||
              got.lvl !== want.lvl || got.vcos !== want.vcos) begin
            $display("%0t: mismatch, expected view=%b u=%h v=%h lvl=%0d cos=%h", $time,
                     want.in_view, want.u, want.v, want.lvl, want.vcos);
            $display("%0t:          actual   view=%b u=%h v=%h lvl=%0d cos=%h", $time,
                     got.in_view, got.u, got.v, got.lvl, got.vcos);
            fails++;
          end
        end
      end
    end
    pending = view_q.size();
  end
endmodule

/* test/frustum_test_project_point_test.sv */
module frustum_test_project_point_test;
  import ftpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fails;
  int                    pending;
  int                    cycles;
  int                    gap_pct;
  int                    stall_pct;

  frustum_test_project_point i_dut (.*);

  frustum_test_project_point_check i_check (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // wait for the pipe to empty, then for latency and the scale table to settle
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_pt(int wx, int wy, int wz, int nx, int ny, int nz,
                         int nr, int fr, int cl);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'b0, cl[20:0], fr[19:0], nr[19:0], nz[20:0], ny[20:0], nx[20:0],
                 wz[20:0], wy[20:0], wx[20:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic int srange(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic camera(int fx, int fy, int bx, int by, logic [19:0] scl);
    cfg_write(REG_FOCAL, {fy[15:0], 16'b0, fx[15:0], 16'b0});
    cfg_write(REG_PRINC, {16'(by / 2), 16'b0, 16'(bx / 2), 16'b0});
    cfg_write(REG_BOUNDS, {32'b0, by[15:0], bx[15:0]});
    cfg_write(REG_SCALE, {44'b0, scl});
  endtask

  // points inside a plausible frustum, or with wide_pct percent odds anything at all
  task automatic random_pt(int wide_pct);
    int z, cl;
    if ($urandom_range(99) < wide_pct) begin
      send_pt($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(1, 1048575), $urandom, $urandom);
    end else begin
      z = $urandom_range(1, 30000);
      cl = ($urandom_range(3) == 0) ? int'($urandom) : -int'($urandom_range(0, 1048576));
      send_pt(srange(z * 7 / 10), srange(z * 7 / 10), z,
              srange(1048576), srange(1048576), srange(1048576),
              $urandom_range(1, 4096), $urandom_range(1000, 1048575), cl);
    end
  endtask

  initial begin
    int wide;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      wide = 20;
      case (ph)
        1: begin
          camera(500, 500, 640, 480, {4'd8, 16'd19661});
          cfg_write(REG_TRANS, 64'd0);
        end
        2: begin
          camera(300, 700, 1024, 768, {4'd0, 16'hffff});
          // diagonal axes with a sign flip on y, small offset
          cfg_write(REG_ROT0, 64'({21'd0, 21'd0, 21'd524288}));
          cfg_write(REG_ROT1, 64'({21'd0, 21'h180000, 21'd0}));
          cfg_write(REG_ROT2, 64'({21'd524288, 21'd0, 21'd0}));
          cfg_write(REG_TRANS, 64'({21'(srange(2000)), 21'(srange(2000)),
                                    21'(srange(2000))}));
        end
        3: begin
          for (int r = 0; r < 8; r++) cfg_write(r[3:0], rand64());
          cfg_write(4'd9, rand64());
          wide = 60;
        end
        4: begin
          cfg_write(REG_ROT0, 64'(ROT0_RST));
          cfg_write(REG_ROT1, 64'(ROT1_RST));
          cfg_write(REG_ROT2, 64'(ROT2_RST));
          cfg_write(REG_TRANS, '1);
          cfg_write(REG_FOCAL, '1);
          cfg_write(REG_PRINC, 64'd0);
          cfg_write(REG_BOUNDS, 64'hffffffff);
          cfg_write(REG_SCALE, {44'b0, 4'd15, 16'd0});
        end
        5: begin
          camera(800, 400, 320, 240, {4'd1, 16'd16384});
          cfg_write(REG_TRANS, 64'({21'd100, 21'h1fff00, 21'd3}));
        end
        default: ;
      endcase
      repeat (10) @(negedge clk);

      if (ph == 1) begin
        send_pt(0, 0, 5120, 0, 0, 524288, 1024, 1048575, -1048576);
        send_pt(0, 0, 0, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(0, 0, -1024, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(16384, 12288, 25600, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(16385, 0, 25600, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(0, 12289, 25600, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(-16384, -12288, 25600, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(1048575, 1048575, 1048575, 1048575, 1048575, 1048575,
                1048575, 1048575, 1048575);
        send_pt(-1048576, -1048576, -1048576, -1048576, -1048576, -1048576,
                1, 0, -1048576);
        send_pt(0, 0, 5120, 0, 0, 524288, 6000, 5000, -1048576);
        send_pt(0, 0, 5120, 0, 0, 524288, 1, 1048575, -1048576);
        send_pt(0, 0, 5120, 0, 0, 524288, 1048575, 1048575, -1048576);
        send_pt(0, 0, 5120, 0, 0, 524288, 1024, 1048575, 524288);
        send_pt(0, 0, 5120, 0, 0, 524288, 1024, 1048575, 524289);
        send_pt(0, 0, 5120, 0, 0, -1048576, 1024, 1048575, -1048576);
        send_pt(0, 0, 5120, 0, 0, 1048575, 1024, 5120, 1048575);
        in_tvalid <= 0;
        drain();
      end

      for (int n = 0; n < 115; n++) begin
        if (n == 60) begin
          in_tvalid <= 0;
          while (pending != 0) @(negedge clk);
        end
        random_pt(wide);
      end
      in_tvalid <= 0;
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* frustum_test_project_point.f */
rtl/ftpp_pkg.sv
rtl/frustum_test_project_point.sv
rtl/ftpp_checker.sv
test/frustum_test_project_point_check.sv
test/frustum_test_project_point_test.sv
